@@ rtl/zip_header_record_parser_assert.svh @@
// Assertion macros shared by the ZIP header record parser checkers.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ZIP_HEADER_RECORD_PARSER_ASSERT_SVH
`define ZIP_HEADER_RECORD_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZHRP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zhrp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ZHRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zhrp assertion failed");

`endif

@@ rtl/zhrp_pkg.sv @@
// Shared types, codes, signatures and field tables of the ZIP header record parser.
// Depends on nothing; used by every module of the block.
package zhrp_pkg;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_FIXED   = 5'b00010,
    PH_NAME    = 5'b00100,
    PH_EXTRA   = 5'b01000,
    PH_COMMENT = 5'b10000
  } phase_t;

  localparam logic [1:0] KIND_LOCAL   = 2'd0;
  localparam logic [1:0] KIND_CENTRAL = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [1:0] ITEM_FIXED   = 2'd0;
  localparam logic [1:0] ITEM_NAME    = 2'd1;
  localparam logic [1:0] ITEM_EXTRA   = 2'd2;
  localparam logic [1:0] ITEM_COMMENT = 2'd3;

  localparam logic [31:0] SIG_LOCAL   = 32'h504B_0304;
  localparam logic [31:0] SIG_CENTRAL = 32'h504B_0102;
  localparam logic [31:0] SIG_END     = 32'h504B_0506;

  localparam logic CFG_KIND_ENABLE = 1'b0;
  localparam logic CFG_MAX_CENTRAL = 1'b1;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
  } sig_match_t;

  function automatic logic [2:0] field_size(input logic [1:0] kind, input logic [3:0] f);
    logic [2:0] sz;
    sz = 3'd0;
    case (kind)
      KIND_CENTRAL: begin
        case (f)
          4'd6, 4'd7, 4'd8, 4'd14, 4'd15: sz = 3'd4;
          default: sz = 3'd2;
        endcase
      end
      KIND_END: begin
        case (f)
          4'd0, 4'd1, 4'd2, 4'd3, 4'd6: sz = 3'd2;
          4'd4, 4'd5: sz = 3'd4;
          default: sz = 3'd0;
        endcase
      end
      default: begin
        case (f)
          4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd8, 4'd9: sz = 3'd2;
          4'd5, 4'd6, 4'd7: sz = 3'd4;
          default: sz = 3'd0;
        endcase
      end
    endcase
    return sz;
  endfunction

  function automatic logic [4:0] field_count(input logic [1:0] kind);
    logic [4:0] n;
    case (kind)
      KIND_CENTRAL: n = 5'd16;
      KIND_END:     n = 5'd7;
      default:      n = 5'd10;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/zhrp_sig_detect.sv @@
// Signature recognizer of the ZIP header record parser.
// Depends on zhrp_pkg for the signatures, kind codes and the match struct.
module zhrp_sig_detect import zhrp_pkg::*; (
  input  logic [31:0] window,
  input  logic [2:0]  kind_enable,
  input  logic [15:0] max_central,
  input  logic [15:0] central_seen,
  output sig_match_t  match
);

  logic central_ok;

  assign central_ok = (max_central == 16'd0) || (central_seen < max_central);

  always_comb begin
    match = '0;
    if (window == SIG_LOCAL && kind_enable[0]) begin
      match.hit  = 1'b1;
      match.kind = KIND_LOCAL;
    end else if (window == SIG_CENTRAL && kind_enable[1] && central_ok) begin
      match.hit  = 1'b1;
      match.kind = KIND_CENTRAL;
    end else if (window == SIG_END && kind_enable[2]) begin
      match.hit  = 1'b1;
      match.kind = KIND_END;
    end
  end

endmodule

@@ rtl/zip_header_record_parser.sv @@
// Top level of the ZIP header record parser: parse state, result register, configuration.
// Depends on zhrp_pkg and instantiates zhrp_sig_detect.

// The parser takes one archive byte per cycle and gives at most one result per byte, in the
// cycle after the byte's transfer, from a single output register. Each byte is handled by
// one pass of logic between the parse state registers and that output register, so a new
// byte is taken every cycle; in_ready is low only while a result waits in the output
// register and out_ready is low. Bytes taken while hunting for a signature and the inner
// bytes of a multi-byte fixed field produce no result. Configuration writes are taken in
// any cycle (cfg_ready is always high) and take effect at once.
module zip_header_record_parser import zhrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [1:0]  out_item_kind,
  output logic [3:0]  out_field_number,
  output logic [31:0] out_field_value,
  output logic        out_record_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [2:0]  kind_enable_r;
  logic [15:0] max_central_r;

  logic [31:0] window_r, window_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [15:0] name_len_r, name_len_nxt;
  logic [15:0] extra_len_r, extra_len_nxt;
  logic [15:0] comment_len_r, comment_len_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] central_seen_r, central_seen_nxt;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [1:0]  out_item_r;
  logic [3:0]  out_fnum_r;
  logic [31:0] out_value_r;
  logic        out_last_r;

  logic        res_valid;
  logic [1:0]  res_item;
  logic [3:0]  res_fnum;
  logic [31:0] res_value;
  logic        res_last;

  logic        in_xfer;
  logic [31:0] hunt_window;
  sig_match_t  sig;
  logic [1:0]  kind_norm;
  logic [2:0]  cur_size;
  logic [31:0] acc_merged;
  logic        do_adv, adv_fixed, adv_name, adv_comment;

  assign in_ready    = !out_valid_r || out_ready;
  assign in_xfer     = in_valid && in_ready;
  assign cfg_ready   = 1'b1;
  assign hunt_window = {window_r[23:0], in_data_byte & BYTE_MASK};
  assign kind_norm   = (kind_r == KIND_LOCAL || kind_r == KIND_CENTRAL || kind_r == KIND_END)
                       ? kind_r : KIND_LOCAL;
  assign cur_size    = field_size(kind_norm, fcnt_r);
  assign acc_merged  = acc_r | ({24'd0, in_data_byte} << {bif_r, 3'b000});

  zhrp_sig_detect u_sig (
    .window       (hunt_window),
    .kind_enable  (kind_enable_r),
    .max_central  (max_central_r),
    .central_seen (central_seen_r),
    .match        (sig)
  );

  always_comb begin
    window_nxt       = window_r;
    phase_nxt        = phase_r;
    kind_nxt         = kind_r;
    fcnt_nxt         = fcnt_r;
    bif_nxt          = bif_r;
    acc_nxt          = acc_r;
    name_len_nxt     = name_len_r;
    extra_len_nxt    = extra_len_r;
    comment_len_nxt  = comment_len_r;
    bytes_left_nxt   = bytes_left_r;
    central_seen_nxt = central_seen_r;
    res_valid        = 1'b0;
    res_item         = ITEM_FIXED;
    res_fnum         = 4'd0;
    res_value        = 32'd0;
    res_last         = 1'b0;
    do_adv           = 1'b0;
    adv_fixed        = 1'b0;
    adv_name         = 1'b0;
    adv_comment      = 1'b0;

    case (phase_r)
      PH_FIXED: begin
        if ({1'b0, bif_r} + 3'd1 < cur_size) begin
          acc_nxt = acc_merged;
          bif_nxt = bif_r + 2'd1;
        end else begin
          res_valid = 1'b1;
          res_item  = ITEM_FIXED;
          res_fnum  = fcnt_r;
          res_value = acc_merged;
          case (kind_norm)
            KIND_CENTRAL: begin
              if (fcnt_r == 4'd9)  name_len_nxt    = acc_merged[15:0];
              if (fcnt_r == 4'd10) extra_len_nxt   = acc_merged[15:0];
              if (fcnt_r == 4'd11) comment_len_nxt = acc_merged[15:0];
            end
            KIND_END: begin
              if (fcnt_r == 4'd6)  comment_len_nxt = acc_merged[15:0];
            end
            default: begin
              if (fcnt_r == 4'd8)  name_len_nxt    = acc_merged[15:0];
              if (fcnt_r == 4'd9)  extra_len_nxt   = acc_merged[15:0];
            end
          endcase
          bif_nxt = 2'd0;
          acc_nxt = 32'd0;
          if ({1'b0, fcnt_r} + 5'd1 >= field_count(kind_norm)) begin
            fcnt_nxt  = 4'd0;
            do_adv    = 1'b1;
            adv_fixed = 1'b1;
          end else begin
            fcnt_nxt = fcnt_r + 4'd1;
          end
        end
      end
      PH_NAME, PH_EXTRA, PH_COMMENT: begin
        res_valid = 1'b1;
        res_fnum  = 4'd0;
        res_value = {24'd0, in_data_byte};
        if (phase_r == PH_NAME) begin
          res_item = ITEM_NAME;
          adv_name = 1'b1;
        end else if (phase_r == PH_EXTRA) begin
          res_item = ITEM_EXTRA;
        end else begin
          res_item    = ITEM_COMMENT;
          adv_comment = 1'b1;
        end
        if (bytes_left_r != 16'd0) bytes_left_nxt = bytes_left_r - 16'd1;
        if (bytes_left_nxt == 16'd0) do_adv = 1'b1;
      end
      default: begin
        phase_nxt  = PH_HUNT;
        window_nxt = hunt_window;
        if (sig.hit) begin
          if (sig.kind == KIND_CENTRAL && central_seen_r != COUNT_MAX) begin
            central_seen_nxt = central_seen_r + 16'd1;
          end
          kind_nxt        = sig.kind;
          phase_nxt       = PH_FIXED;
          fcnt_nxt        = 4'd0;
          bif_nxt         = 2'd0;
          acc_nxt         = 32'd0;
          name_len_nxt    = 16'd0;
          extra_len_nxt   = 16'd0;
          comment_len_nxt = 16'd0;
          bytes_left_nxt  = 16'd0;
          window_nxt      = 32'd0;
        end
      end
    endcase

    if (do_adv) begin
      if (adv_fixed && name_len_nxt != 16'd0) begin
        phase_nxt      = PH_NAME;
        bytes_left_nxt = name_len_nxt;
      end else if ((adv_fixed || adv_name) && extra_len_nxt != 16'd0) begin
        phase_nxt      = PH_EXTRA;
        bytes_left_nxt = extra_len_nxt;
      end else if (!adv_comment && comment_len_nxt != 16'd0) begin
        phase_nxt      = PH_COMMENT;
        bytes_left_nxt = comment_len_nxt;
      end else begin
        phase_nxt      = PH_HUNT;
        bytes_left_nxt = 16'd0;
        window_nxt     = 32'd0;
        res_last       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_enable_r <= 3'd7;
      max_central_r <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_KIND_ENABLE) kind_enable_r <= cfg_data[2:0];
      if (cfg_index == CFG_MAX_CENTRAL) max_central_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r       <= 32'd0;
      phase_r        <= PH_HUNT;
      kind_r         <= KIND_LOCAL;
      fcnt_r         <= 4'd0;
      bif_r          <= 2'd0;
      acc_r          <= 32'd0;
      name_len_r     <= 16'd0;
      extra_len_r    <= 16'd0;
      comment_len_r  <= 16'd0;
      bytes_left_r   <= 16'd0;
      central_seen_r <= 16'd0;
    end else if (in_xfer) begin
      window_r       <= window_nxt;
      phase_r        <= phase_nxt;
      kind_r         <= kind_nxt;
      fcnt_r         <= fcnt_nxt;
      bif_r          <= bif_nxt;
      acc_r          <= acc_nxt;
      name_len_r     <= name_len_nxt;
      extra_len_r    <= extra_len_nxt;
      comment_len_r  <= comment_len_nxt;
      bytes_left_r   <= bytes_left_nxt;
      central_seen_r <= central_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      out_kind_r  <= kind_r;
      out_item_r  <= res_item;
      out_fnum_r  <= res_fnum;
      out_value_r <= res_value;
      out_last_r  <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_record_kind  = out_kind_r;
  assign out_item_kind    = out_item_r;
  assign out_field_number = out_fnum_r;
  assign out_field_value  = out_value_r;
  assign out_record_last  = out_last_r;

endmodule

@@ rtl/zip_header_record_parser_checker.sv @@
// Port-level checker for the ZIP header record parser, bound to the top level.
// Depends on zhrp_pkg and the macros in zip_header_record_parser_assert.svh.
`include "zip_header_record_parser_assert.svh"

module zip_header_record_parser_checker import zhrp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_record_kind,
  input logic [1:0]  out_item_kind,
  input logic [3:0]  out_field_number,
  input logic [31:0] out_field_value,
  input logic        out_record_last,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [15:0] cfg_data
);

  `ZHRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_field_value) && $stable(out_item_kind) && $stable(out_record_last))
  `ZHRP_ASSERT_SAME(a_kind_range, out_valid, out_record_kind != 2'd3)
  `ZHRP_ASSERT_SAME(a_pass_fnum, out_valid && out_item_kind != ITEM_FIXED, out_field_number == 4'd0 && out_field_value[31:8] == 24'd0)
  `ZHRP_ASSERT_SAME(a_end_sections, out_valid && out_record_kind == KIND_END, out_item_kind == ITEM_FIXED || out_item_kind == ITEM_COMMENT)
  `ZHRP_ASSERT_SAME(a_local_sections, out_valid && out_record_kind == KIND_LOCAL, out_item_kind != ITEM_COMMENT)

endmodule

bind zip_header_record_parser zip_header_record_parser_checker u_checker (.*);

@@ tb/sv/zip_header_record_parser_test.sv @@
// Self-checking testbench for zip_header_record_parser: ZIP header byte streams, records and noise.
// Depends on zhrp_pkg and the parser RTL; a built-in parse model predicts every result transfer.
module zip_header_record_parser_test;
  import zhrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_QUIET      = 8;

  localparam logic [15:0] LOCAL_WIDE   = 16'b0000_0000_1110_0000;
  localparam logic [15:0] CENTRAL_WIDE = 16'b1100_0001_1100_0000;
  localparam logic [15:0] END_WIDE     = 16'b0000_0000_0011_0000;

  localparam int LOCAL_NAME_F      = 8;
  localparam int LOCAL_EXTRA_F     = 9;
  localparam int CENTRAL_NAME_F    = 9;
  localparam int CENTRAL_EXTRA_F   = 10;
  localparam int CENTRAL_COMMENT_F = 11;
  localparam int END_COMMENT_F     = 6;

  typedef enum logic [1:0] {OP_BYTE, OP_CFG, OP_DRAIN} stim_kind_t;

  typedef struct packed {
    stim_kind_t  kind;
    logic        cfg_sel;
    logic [15:0] value;
  } stim_op_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [1:0]  item_kind;
    logic [3:0]  field_number;
    logic [31:0] field_value;
    logic        record_last;
  } parsed_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_record_kind;
  logic [1:0]  out_item_kind;
  logic [3:0]  out_field_number;
  logic [31:0] out_field_value;
  logic        out_record_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  stim_op_t     pending_ops[$];
  parsed_item_t expected_items[$];

  logic [2:0]  cfg_kind_enable;
  logic [15:0] cfg_max_central;
  logic [31:0] ps_window;
  phase_t      ps_phase;
  logic [1:0]  ps_kind;
  logic [3:0]  ps_field;
  int          ps_byte;
  logic [31:0] ps_acc;
  logic [15:0] ps_name_len;
  logic [15:0] ps_extra_len;
  logic [15:0] ps_comment_len;
  logic [15:0] ps_bytes_left;
  logic [15:0] ps_central_seen;

  int records_started[3];
  int bytes_built;
  int bytes_sent;
  int results_checked;
  int writes_done;
  int fail_count;
  int tx_wait;
  int rx_wait;
  int settle;
  bit tx_burst;
  bit rx_burst;

  zip_header_record_parser DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_record_kind  (out_record_kind),
    .out_item_kind    (out_item_kind),
    .out_field_number (out_field_number),
    .out_field_value  (out_field_value),
    .out_record_last  (out_record_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int field_bytes(input logic [1:0] kind, input int f);
    logic [15:0] wide;
    case (kind)
      KIND_CENTRAL: wide = CENTRAL_WIDE;
      KIND_END:     wide = END_WIDE;
      default:      wide = LOCAL_WIDE;
    endcase
    return wide[f] ? 4 : 2;
  endfunction

  function automatic int fields_in(input logic [1:0] kind);
    case (kind)
      KIND_CENTRAL: return 16;
      KIND_END:     return 7;
      default:      return 10;
    endcase
  endfunction

  function automatic void start_record(input logic [1:0] kind);
    ps_kind = kind;
    ps_phase = PH_FIXED;
    ps_field = 4'd0;
    ps_byte = 0;
    ps_acc = 32'h0;
    ps_name_len = 16'h0;
    ps_extra_len = 16'h0;
    ps_comment_len = 16'h0;
    ps_bytes_left = 16'h0;
    ps_window = 32'h0;
    records_started[kind]++;
  endfunction

  function automatic void reset_model();
    cfg_kind_enable = 3'd7;
    cfg_max_central = 16'h0;
    ps_window = 32'h0;
    ps_phase = PH_HUNT;
    ps_kind = KIND_LOCAL;
    ps_field = 4'd0;
    ps_byte = 0;
    ps_acc = 32'h0;
    ps_name_len = 16'h0;
    ps_extra_len = 16'h0;
    ps_comment_len = 16'h0;
    ps_bytes_left = 16'h0;
    ps_central_seen = 16'h0;
  endfunction

  // Moves to the first non-empty section after the given one; returns 1 when the record ends.
  function automatic logic next_section(input phase_t from);
    if (from < PH_NAME && ps_name_len != 0) begin
      ps_phase = PH_NAME;
      ps_bytes_left = ps_name_len;
      return 1'b0;
    end
    if (from < PH_EXTRA && ps_extra_len != 0) begin
      ps_phase = PH_EXTRA;
      ps_bytes_left = ps_extra_len;
      return 1'b0;
    end
    if (from < PH_COMMENT && ps_comment_len != 0) begin
      ps_phase = PH_COMMENT;
      ps_bytes_left = ps_comment_len;
      return 1'b0;
    end
    ps_phase = PH_HUNT;
    ps_bytes_left = 16'h0;
    ps_window = 32'h0;
    return 1'b1;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    parsed_item_t r;
    int f;
    phase_t ph;
    case (ps_phase)
      PH_FIXED: begin
        f = ps_field;
        ps_acc = ps_acc | ({24'h0, b} << (8 * ps_byte));
        if (ps_byte + 1 < field_bytes(ps_kind, f)) begin
          ps_byte++;
        end else begin
          if (ps_kind == KIND_LOCAL) begin
            if (f == LOCAL_NAME_F) ps_name_len = ps_acc[15:0];
            if (f == LOCAL_EXTRA_F) ps_extra_len = ps_acc[15:0];
          end else if (ps_kind == KIND_CENTRAL) begin
            if (f == CENTRAL_NAME_F) ps_name_len = ps_acc[15:0];
            if (f == CENTRAL_EXTRA_F) ps_extra_len = ps_acc[15:0];
            if (f == CENTRAL_COMMENT_F) ps_comment_len = ps_acc[15:0];
          end else begin
            if (f == END_COMMENT_F) ps_comment_len = ps_acc[15:0];
          end
          r.record_kind = ps_kind;
          r.item_kind = ITEM_FIXED;
          r.field_number = 4'(f);
          r.field_value = ps_acc;
          r.record_last = 1'b0;
          ps_byte = 0;
          ps_acc = 32'h0;
          if (f + 1 >= fields_in(ps_kind)) begin
            ps_field = 4'd0;
            r.record_last = next_section(PH_FIXED);
          end else begin
            ps_field = 4'(f + 1);
          end
          expected_items.push_back(r);
        end
      end
      PH_NAME, PH_EXTRA, PH_COMMENT: begin
        ph = ps_phase;
        r.record_kind = ps_kind;
        case (ph)
          PH_NAME:  r.item_kind = ITEM_NAME;
          PH_EXTRA: r.item_kind = ITEM_EXTRA;
          default:  r.item_kind = ITEM_COMMENT;
        endcase
        r.field_number = 4'd0;
        r.field_value = {24'h0, b};
        r.record_last = 1'b0;
        if (ps_bytes_left != 0) ps_bytes_left = ps_bytes_left - 16'd1;
        if (ps_bytes_left == 0) r.record_last = next_section(ph);
        expected_items.push_back(r);
      end
      default: begin
        ps_phase = PH_HUNT;
        ps_window = {ps_window[23:0], b};
        if (ps_window == SIG_LOCAL && cfg_kind_enable[0]) begin
          start_record(KIND_LOCAL);
        end else if (ps_window == SIG_CENTRAL && cfg_kind_enable[1] &&
                     (cfg_max_central == 0 || ps_central_seen < cfg_max_central)) begin
          if (ps_central_seen < COUNT_MAX) ps_central_seen++;
          start_record(KIND_CENTRAL);
        end else if (ps_window == SIG_END && cfg_kind_enable[2]) begin
          start_record(KIND_END);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : byte_driver
    stim_op_t op;
    logic next_valid;
    logic next_cfg;
    if (!rst_n) begin
      reset_model();
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      tx_wait = 0;
      settle = 0;
    end else begin
      next_valid = in_valid;
      next_cfg = cfg_valid;
      if (in_valid && in_ready) begin
        parse_byte(in_data_byte);
        bytes_sent++;
        next_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_KIND_ENABLE) cfg_kind_enable = cfg_data[2:0];
        else cfg_max_central = cfg_data;
        writes_done++;
        next_cfg = 1'b0;
      end
      if (!next_valid && !next_cfg) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops[0];
          if (op.kind == OP_BYTE) begin
            void'(pending_ops.pop_front());
            next_valid = 1'b1;
            in_data_byte <= op.value[7:0];
            if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
            tx_wait = tx_burst ? 0 : $urandom_range(0, 19);
          end else if (expected_items.size() != 0 || out_valid) begin
            settle = 0;
          end else if (settle < SETTLE_CYCLES) begin
            settle++;
          end else begin
            void'(pending_ops.pop_front());
            settle = 0;
            if (op.kind == OP_CFG) begin
              next_cfg = 1'b1;
              cfg_index <= op.cfg_sel;
              cfg_data <= op.value;
            end
          end
        end
      end
      in_valid <= next_valid;
      cfg_valid <= next_cfg;
    end
  end

  always @(posedge clk) begin : result_monitor
    parsed_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_items.size() == 0) begin
          $error("result transfer with no expected item: kind %0d item %0d field %0d value 0x%0h",
                 out_record_kind, out_item_kind, out_field_number, out_field_value);
          fail_count++;
        end else begin
          want = expected_items.pop_front();
          check_field("record_kind", want.record_kind, out_record_kind);
          check_field("item_kind", want.item_kind, out_item_kind);
          check_field("field_number", want.field_number, out_field_number);
          check_field("field_value", want.field_value, out_field_value);
          check_field("record_last", want.record_last, out_record_last);
        end
        results_checked++;
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_ops.push_back('{OP_BYTE, 1'b0, {8'h00, b}});
    bytes_built++;
  endtask

  task automatic push_write(input logic sel, input logic [15:0] value);
    pending_ops.push_back('{OP_CFG, sel, value});
  endtask

  task automatic push_drain();
    pending_ops.push_back('{OP_DRAIN, 1'b0, 16'h0});
  endtask

  task automatic push_sig(input logic [31:0] sig);
    for (int i = 3; i >= 0; i--) push_byte(sig[8*i +: 8]);
  endtask

  // A fill below zero gives random content; otherwise every content byte is the fill value.
  task automatic push_record(input logic [1:0] kind, input int name_n, input int extra_n,
                             input int comment_n, input int fill);
    logic [31:0] v;
    int n;
    case (kind)
      KIND_CENTRAL: push_sig(SIG_CENTRAL);
      KIND_END:     push_sig(SIG_END);
      default:      push_sig(SIG_LOCAL);
    endcase
    for (int f = 0; f < fields_in(kind); f++) begin
      v = (fill < 0) ? $urandom : {4{fill[7:0]}};
      if ((kind == KIND_LOCAL && f == LOCAL_NAME_F) || (kind == KIND_CENTRAL && f == CENTRAL_NAME_F))
        v[15:0] = name_n[15:0];
      if ((kind == KIND_LOCAL && f == LOCAL_EXTRA_F) || (kind == KIND_CENTRAL && f == CENTRAL_EXTRA_F))
        v[15:0] = extra_n[15:0];
      if ((kind == KIND_CENTRAL && f == CENTRAL_COMMENT_F) || (kind == KIND_END && f == END_COMMENT_F))
        v[15:0] = comment_n[15:0];
      n = field_bytes(kind, f);
      for (int i = 0; i < n; i++) push_byte(v[8*i +: 8]);
    end
    n = name_n + extra_n + comment_n;
    repeat (n) push_byte((fill < 0) ? 8'($urandom) : fill[7:0]);
  endtask

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 3);
    if (r < 9) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  initial begin : main_sequence
    int target;
    int pick;
    logic [2:0] en;
    logic [15:0] maxc;
    int idle_run;
    int quiet;
    bit timed_out;

    push_record(KIND_END, 0, 0, 0, 8'hFF);
    push_drain();
    push_record(KIND_LOCAL, 1, 1, 0, 8'h00);
    push_write(CFG_KIND_ENABLE, 16'($urandom) & 16'hFFF8);
    push_sig(SIG_LOCAL);
    push_sig(SIG_CENTRAL);
    push_sig(SIG_END);
    push_write(CFG_KIND_ENABLE, (16'($urandom) & 16'hFFF8) | 16'd7);
    push_write(CFG_MAX_CENTRAL, 16'd1);
    push_record(KIND_CENTRAL, 0, 0, 1, -1);
    push_sig(SIG_CENTRAL);
    push_byte(8'h50);
    push_record(KIND_LOCAL, 0, 2, 0, -1);
    push_write(CFG_MAX_CENTRAL, 16'd0);
    push_record(KIND_CENTRAL, 260, 0, 3, -1);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin en = 3'd7; maxc = 16'd0; end
        1:       begin en = 3'd0; maxc = COUNT_MAX; end
        2:       begin en = 3'($urandom); maxc = 16'($urandom_range(1, 20)); end
        3:       begin en = 3'd7; maxc = COUNT_MAX; end
        4:       begin en = 3'($urandom_range(1, 6)); maxc = 16'd0; end
        default: begin en = 3'd7; maxc = 16'($urandom_range(1, 60)); end
      endcase
      push_write(CFG_KIND_ENABLE, (16'($urandom) & 16'hFFF8) | {13'h0, en});
      push_write(CFG_MAX_CENTRAL, maxc);
      target = bytes_built + 20;
      while (bytes_built < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          push_record(KIND_LOCAL, rand_len(), rand_len(), 0, -1);
        end else if (pick < 50) begin
          push_record(KIND_CENTRAL, rand_len(), rand_len(), rand_len(), -1);
        end else if (pick < 62) begin
          push_record(KIND_END, 0, 0, rand_len(), -1);
        end else if (pick < 78) begin
          repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        end else if (pick < 88) begin
          push_byte(8'h50);
          push_byte(8'h4B);
          push_byte(8'h01 + 8'(2 * $urandom_range(0, 2)));
          push_byte(8'($urandom));
        end else if (pick < 95) begin
          push_byte(8'h50);
          push_record(2'($urandom_range(0, 2)), rand_len(), 0, rand_len(), -1);
        end else begin
          push_drain();
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    idle_run = 0;
    quiet = 0;
    timed_out = 1'b0;
    while (!timed_out && quiet < END_QUIET) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) timed_out = 1'b1;
      if (pending_ops.size() == 0 && !in_valid && !cfg_valid && expected_items.size() == 0)
        quiet++;
      else
        quiet = 0;
    end

    if (timed_out) $display("Watchdog expired after %0d cycles without a transfer.", idle_run);
    $display("Sent %0d bytes and checked %0d results over %0d register writes.",
             bytes_sent, results_checked, writes_done);
    $display("Records parsed: %0d local, %0d central, %0d end; %0d mismatches.",
             records_started[KIND_LOCAL], records_started[KIND_CENTRAL],
             records_started[KIND_END], fail_count);
    if (!timed_out && fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
